### sv/rscp_pkg.sv
package rscp_pkg;

    localparam int RAW_BITS_DEF = 20;
    localparam int FIELD_BITS   = 20;
    localparam int GAIN_BITS    = 31;
    localparam int ACC_BITS     = 64;
    localparam int OPND_BITS    = 32;

    localparam logic [GAIN_BITS-1:0] UNITY     = 31'd1000000;
    localparam logic [OPND_BITS-1:0] CCT_SLOPE = 32'd3724;
    localparam logic [ACC_BITS-1:0]  CCT_BASE  = 64'd1525;
    localparam logic [OPND_BITS-1:0] AVG_DIV   = 32'd3;

    localparam int IN_DATA_BITS  = 120;
    localparam int OUT_DATA_BITS = 200;

    typedef enum logic [1:0] {
        OP_MEASURE   = 2'd0,
        OP_CALIBRATE = 2'd1,
        OP_RESTORE   = 2'd2,
        OP_LOAD      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_RUN,
        S_FIN
    } state_t;

    // Sequencer steps; each but M_AVG and C_END starts one multiply or divide pass,
    // and a step may first store the result of the pass before it.
    typedef enum logic [4:0] {
        M_MUL_R, M_DIV_R, M_MUL_G, M_DIV_G, M_MUL_B, M_DIV_B, M_MUL_I, M_DIV_I,
        M_MUL_U, M_MUL_K, M_DIV_S, M_DIV_U, M_DIV_3, M_AVG,
        C_MUL_R, C_DIV_R, C_MUL_G, C_DIV_G, C_MUL_B, C_DIV_B, C_END
    } step_t;

    function automatic logic [GAIN_BITS-1:0] sat31(input logic [ACC_BITS-1:0] v);
        logic [GAIN_BITS-1:0] r;
        r = (v[ACC_BITS-1:GAIN_BITS] != '0) ? '1 : v[GAIN_BITS-1:0];
        return r;
    endfunction

endpackage

### sv/rgb_sensor_color_processor.sv
// One item is in work at a time: the next word is taken the cycle after the
// result is registered, and a stalled result word holds the block in its final
// state. Measure and calibrate run their passes on one shared bit-serial
// multiplier and one restoring divider; restore and load run no passes.
// Reset (rst_n low, asynchronous) sets all four gains to 1000000 and empties
// the output register.
module rgb_sensor_color_processor #(
    parameter int RAW_BITS = rscp_pkg::RAW_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // raw_red, raw_green, raw_blue, raw_infrared, factor_channel, factor_value
    input  logic [rscp_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // operation
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // scaled_red, scaled_green, scaled_blue, scaled_infrared, peak_rgb,
    // average_rgb, color_temperature
    output logic [rscp_pkg::OUT_DATA_BITS-1:0] m_tdata,
    // status
    output logic                               m_tuser
);
    import rscp_pkg::*;

    // Raw bits above RAW_BITS are ignored.
    localparam logic [FIELD_BITS-1:0] RAW_MASK = (RAW_BITS >= FIELD_BITS) ? '1 :
        FIELD_BITS'((64'd1 << RAW_BITS) - 64'd1);

    state_t state_reg, state_next;
    step_t  step_reg, step_succ;

    op_t                   op_reg;
    logic [FIELD_BITS-1:0] r_reg, g_reg, b_reg, i_reg;
    logic [GAIN_BITS-1:0]  gain_reg [4];

    logic [ACC_BITS-1:0]   acc_reg, mcand_reg;
    logic [OPND_BITS-1:0]  opnd_reg, rem_reg;
    logic                  is_div_reg;
    logic [5:0]            cnt_reg;

    logic [GAIN_BITS-1:0]  sr_reg, sg_reg, sb_reg, si_reg, cct_reg;
    logic [FIELD_BITS-1:0] avg_reg;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg;
    logic                  m_tuser_reg;

    logic                  in_fire, out_free;
    logic [FIELD_BITS-1:0] peak, pk_rg;
    logic [FIELD_BITS+1:0] sum_rgb;

    // Decode of the current step.
    logic                  st_div, st_finish;
    logic [ACC_BITS-1:0]   st_a;
    logic [OPND_BITS-1:0]  st_b;

    // Divider iteration.
    logic [OPND_BITS:0]    dv_t;
    logic                  dv_ge;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign pk_rg    = (r_reg > g_reg) ? r_reg : g_reg;
    assign peak     = (pk_rg > b_reg) ? pk_rg : b_reg;
    assign sum_rgb  = {2'b00, r_reg} + {2'b00, g_reg} + {2'b00, b_reg};

    assign dv_t  = {rem_reg, acc_reg[ACC_BITS-1]};
    assign dv_ge = dv_t >= {1'b0, opnd_reg};

    always_comb
    begin
        st_div    = 1'b0;
        st_finish = 1'b0;
        st_a      = acc_reg;
        st_b      = {1'b0, UNITY};
        step_succ = step_reg;
        unique case (step_reg)
            M_MUL_R:
            begin
                st_a = ACC_BITS'(r_reg); st_b = {1'b0, gain_reg[0]}; step_succ = M_DIV_R;
            end
            M_DIV_R: begin st_div = 1'b1; step_succ = M_MUL_G; end
            M_MUL_G:
            begin
                st_a = ACC_BITS'(g_reg); st_b = {1'b0, gain_reg[1]}; step_succ = M_DIV_G;
            end
            M_DIV_G: begin st_div = 1'b1; step_succ = M_MUL_B; end
            M_MUL_B:
            begin
                st_a = ACC_BITS'(b_reg); st_b = {1'b0, gain_reg[2]}; step_succ = M_DIV_B;
            end
            M_DIV_B: begin st_div = 1'b1; step_succ = M_MUL_I; end
            M_MUL_I:
            begin
                st_a = ACC_BITS'(i_reg); st_b = {1'b0, gain_reg[3]}; step_succ = M_DIV_I;
            end
            M_DIV_I: begin st_div = 1'b1; step_succ = M_MUL_U; end
            M_MUL_U: begin st_a = ACC_BITS'(sb_reg); step_succ = M_MUL_K; end
            M_MUL_K: begin st_b = CCT_SLOPE; step_succ = M_DIV_S; end
            M_DIV_S: begin st_div = 1'b1; st_b = {1'b0, sr_reg}; step_succ = M_DIV_U; end
            M_DIV_U: begin st_div = 1'b1; step_succ = M_DIV_3; end
            M_DIV_3:
            begin
                st_div = 1'b1; st_a = ACC_BITS'(sum_rgb); st_b = AVG_DIV; step_succ = M_AVG;
            end
            M_AVG:   st_finish = 1'b1;
            C_MUL_R, C_MUL_G, C_MUL_B:
            begin
                st_a = ACC_BITS'(peak);
                step_succ = (step_reg == C_MUL_R) ? C_DIV_R :
                            (step_reg == C_MUL_G) ? C_DIV_G : C_DIV_B;
            end
            C_DIV_R: begin st_div = 1'b1; st_b = OPND_BITS'(r_reg); step_succ = C_MUL_G; end
            C_DIV_G: begin st_div = 1'b1; st_b = OPND_BITS'(g_reg); step_succ = C_MUL_B; end
            C_DIV_B: begin st_div = 1'b1; st_b = OPND_BITS'(b_reg); step_succ = C_END; end
            C_END:   st_finish = 1'b1;
            default: st_finish = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                    state_next = (op_t'(s_tuser) == OP_MEASURE ||
                                  op_t'(s_tuser) == OP_CALIBRATE) ? S_STEP : S_FIN;
            S_STEP: state_next = st_finish ? S_FIN : S_RUN;
            S_RUN:  if (cnt_reg == '0) state_next = S_STEP;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
        m_tuser  = m_tuser_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= M_MUL_R;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
                gain_reg[k] <= UNITY;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_fire)
                    begin
                        step_reg <= (op_t'(s_tuser) == OP_CALIBRATE) ? C_MUL_R : M_MUL_R;
                        if (op_t'(s_tuser) == OP_RESTORE)
                        begin
                            for (int k = 0; k < 3; k++)
                                gain_reg[k] <= UNITY;
                        end
                        else if (op_t'(s_tuser) == OP_LOAD)
                            gain_reg[s_tdata[81:80]] <= s_tdata[112:82];
                    end
                S_STEP:
                begin
                    step_reg <= step_succ;
                    if (step_reg == C_MUL_G && r_reg != '0) gain_reg[0] <= sat31(acc_reg);
                    if (step_reg == C_MUL_B && g_reg != '0) gain_reg[1] <= sat31(acc_reg);
                    if (step_reg == C_END && b_reg != '0)   gain_reg[2] <= sat31(acc_reg);
                end
                default: ;
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg <= op_t'(s_tuser);
            r_reg  <= s_tdata[19:0]  & RAW_MASK;
            g_reg  <= s_tdata[39:20] & RAW_MASK;
            b_reg  <= s_tdata[59:40] & RAW_MASK;
            i_reg  <= s_tdata[79:60] & RAW_MASK;
        end
        if (state_reg == S_STEP)
        begin
            case (step_reg)
                M_MUL_G: sr_reg  <= sat31(acc_reg);
                M_MUL_B: sg_reg  <= sat31(acc_reg);
                M_MUL_I: sb_reg  <= sat31(acc_reg);
                M_MUL_U: si_reg  <= sat31(acc_reg);
                M_DIV_3: cct_reg <= (sr_reg == '0) ? '0 : sat31(acc_reg + CCT_BASE);
                M_AVG:   avg_reg <= acc_reg[FIELD_BITS-1:0];
                default: ;
            endcase
            is_div_reg <= st_div;
            opnd_reg   <= st_b;
            rem_reg    <= '0;
            mcand_reg  <= st_a;
            acc_reg    <= st_div ? st_a : '0;
            cnt_reg    <= st_div ? 6'd63 : 6'd31;
        end
        else if (state_reg == S_RUN)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (is_div_reg)
            begin
                rem_reg <= dv_ge ? OPND_BITS'(dv_t - {1'b0, opnd_reg}) : dv_t[OPND_BITS-1:0];
                acc_reg <= {acc_reg[ACC_BITS-2:0], dv_ge};
            end
            else
            begin
                if (opnd_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg <= {mcand_reg[ACC_BITS-2:0], 1'b0};
                opnd_reg  <= {1'b0, opnd_reg[OPND_BITS-1:1]};
            end
        end
        if (state_reg == S_FIN && out_free)
        begin
            if (op_reg == OP_MEASURE)
            begin
                m_tdata_reg <= {5'd0, cct_reg, avg_reg, peak, si_reg, sb_reg, sg_reg, sr_reg};
                m_tuser_reg <= (sr_reg == '0);
            end
            else
            begin
                m_tdata_reg <= '0;
                m_tuser_reg <= (op_reg == OP_CALIBRATE) &&
                               (r_reg == '0 || g_reg == '0 || b_reg == '0);
            end
        end
    end

endmodule

### sv/rscp_checker.sv
module rscp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [199:0] m_tdata,
    input logic         m_tuser
);

    // A stalled word holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // One sample is in work at a time.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample taken while one is in work");

    // The truncated average never exceeds the peak.
    a_avg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[143:124] >= m_tdata[163:144])
        else $error("average above peak");

    // A zero divisor leaves the color temperature at zero.
    a_cct: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[194:164] == 31'd0)
        else $error("color temperature set with error status");

endmodule

bind rgb_sensor_color_processor rscp_checker u_rscp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
